// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the MD5 engine RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/md5_pkg.sv
// ---------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables of the MD5 engine.
// ---------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Message buffer write request
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } ram_wr_t;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_PAD    = 10'b00_0000_0010,
        S_ZERO   = 10'b00_0000_0100,
        S_LEN_LO = 10'b00_0000_1000,
        S_LEN_HI = 10'b00_0001_0000,
        S_LOAD   = 10'b00_0010_0000,
        S_PRE    = 10'b00_0100_0000,
        S_ROUND  = 10'b00_1000_0000,
        S_ADD    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    // What follows a block compression
    typedef enum logic [1:0] {
        JOB_DATA  = 2'd0,
        JOB_EXTRA = 2'd1,
        JOB_FINAL = 2'd2
    } job_t;

    function automatic logic [31:0] k_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] rl;
        logic [3:0] g;
        rl = r[3:0];
        case (r[5:4])
            2'd0:    g = rl;
            2'd1:    g = 4'(rl * 4'd5 + 4'd1);
            2'd2:    g = 4'(rl * 4'd3 + 4'd5);
            2'd3:    g = 4'(rl * 4'd7);
            default: g = rl;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] phase,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// File: sv/md5_msg_ram.sv
// ---------------------------------------------------------------------------
// md5_msg_ram
// 16 x 32 message block buffer, one write and one registered read port.
// ---------------------------------------------------------------------------
module md5_msg_ram (
    input  logic             clk,
    input  md5_pkg::ram_wr_t wr_req,
    input  logic [3:0]       rd_addr,
    output logic [31:0]      rd_data
);
    import md5_pkg::*;

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    always_ff @(posedge clk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/md5_hash_engine_core.sv
// ---------------------------------------------------------------------------
// md5_hash_engine_core
// Streaming MD5 digest engine: message bytes in, four digest words out.
// ---------------------------------------------------------------------------
// Usage:
//  - s_axis: one item per handshake. tdata = message byte, tuser[0] = byte
//    present, tlast = end of message. An end item without a byte is legal
//    (empty message, or a trailer after the last byte).
//  - m_axis: four items per message, word A first. tdata = digest word
//    (digest bytes are each word's bytes little-endian), tuser = word index,
//    tlast on word 3.
//  - Bytes are packed into a 16-word block buffer (single-port-write RAM,
//    registered read). Byte items are taken while idle; every 64th byte
//    starts a compression (working-word load, operand prefetch, 64 rounds,
//    chaining add), during which no further bytes are accepted. The round
//    loop of one shared round unit limits the sustained byte rate.
//  - End of message: pad word write, up to 15 zero-word writes, two length
//    writes, then one or two compressions before the first digest word
//    appears.
//  - The digest sits in its own output registers, so the next message is
//    accepted while the receiver stalls; only a second digest waits until
//    the first has fully drained.
//  - Reset (aresetn low, synchronous) loads the MD5 IV, clears the byte
//    count and drops any pending digest. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module md5_hash_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import md5_pkg::*;

    // control
    state_t      state_reg, state_next;
    job_t        job_reg, job_next;
    logic        eom_pend_reg, eom_pend_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [3:0]  fill_reg, fill_next;
    logic        zero_to_end_reg, zero_to_end_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic        out_busy_reg, out_busy_next;
    logic [1:0]  out_idx_reg, out_idx_next;

    // datapath
    logic [31:0] acc_reg, acc_next;
    logic [31:0] pre_reg, pre_next;
    logic [31:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [31:0] wa_next, wb_next, wc_next, wd_next;
    logic [31:0] out_word_reg [4];
    logic        out_load;

    // RAM
    ram_wr_t     ram_wr;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_q;

    logic        s_fire, m_fire;
    logic [1:0]  lane;
    logic [3:0]  pad_w;
    logic [31:0] byte_word, pad_word;
    logic [5:0]  rd_round, k_idx;
    logic [31:0] f_val, t_sum, rot_val, pre_base;
    logic [63:0] rot_dbl;

    md5_msg_ram u_ram (
        .clk     (aclk),
        .wr_req  (ram_wr),
        .rd_addr (ram_raddr),
        .rd_data (ram_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // byte lane merge: lane 0 starts a fresh word, higher lanes OR in
    assign lane  = cnt_reg[1:0];
    assign pad_w = cnt_reg[5:2];
    assign byte_word = (lane == 2'd0) ? {24'h0, s_axis_tdata}
                     : (acc_reg | (32'(s_axis_tdata) << {lane, 3'b000}));
    assign pad_word  = (lane == 2'd0) ? {24'h0, PAD_BYTE}
                     : (acc_reg | (32'(PAD_BYTE) << {lane, 3'b000}));

    // round unit
    assign f_val   = round_f(rnd_reg[5:4], wb_reg, wc_reg, wd_reg);
    assign t_sum   = pre_reg + f_val;
    assign rot_dbl = {t_sum, t_sum} << rot_amt(rnd_reg);
    assign rot_val = rot_dbl[63:32];

    // prefetch: read address two rounds ahead, K + a one round ahead
    always_comb begin
        case (state_reg)
            S_LOAD:  rd_round = 6'd0;
            S_PRE:   rd_round = 6'd1;
            default: rd_round = 6'(rnd_reg + 6'd2);
        endcase
    end
    assign ram_raddr = msg_index(rd_round);
    assign k_idx     = (state_reg == S_PRE) ? 6'd0 : 6'(rnd_reg + 6'd1);
    // next round's a is the current d (or the loaded A before round 0)
    assign pre_base  = (state_reg == S_PRE) ? wa_reg : wd_reg;

    always_comb begin
        state_next       = state_reg;
        job_next         = job_reg;
        eom_pend_next    = eom_pend_reg;
        cnt_next         = cnt_reg;
        fill_next        = fill_reg;
        zero_to_end_next = zero_to_end_reg;
        rnd_next         = rnd_reg;
        out_busy_next    = out_busy_reg;
        out_idx_next     = out_idx_reg;
        acc_next         = acc_reg;
        pre_next         = pre_reg;
        wa_next          = wa_reg;
        wb_next          = wb_reg;
        wc_next          = wc_reg;
        wd_next          = wd_reg;
        chain_next       = chain_reg;
        out_load         = 1'b0;
        ram_wr.en        = 1'b0;
        ram_wr.addr      = pad_w;
        ram_wr.data      = pad_word;

        if (m_fire) begin
            if (out_idx_reg == 2'd3) begin
                out_busy_next = 1'b0;
            end else begin
                out_idx_next = out_idx_reg + 2'd1;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser[0]) begin
                        acc_next = byte_word;
                        cnt_next = cnt_reg + 64'd1;
                        if (lane == 2'd3) begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = pad_w;
                            ram_wr.data = byte_word;
                        end
                    end
                    if (s_axis_tuser[0] && cnt_reg[5:0] == 6'd63) begin
                        job_next      = JOB_DATA;
                        eom_pend_next = s_axis_tlast;
                        state_next    = S_LOAD;
                    end else if (s_axis_tlast) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = pad_w;
                ram_wr.data = pad_word;
                if (pad_w == 4'd15) begin
                    job_next   = JOB_EXTRA;
                    state_next = S_LOAD;
                end else if (pad_w == 4'd14) begin
                    fill_next        = 4'd15;
                    zero_to_end_next = 1'b1;
                    state_next       = S_ZERO;
                end else if (pad_w == 4'd13) begin
                    state_next = S_LEN_LO;
                end else begin
                    fill_next        = pad_w + 4'd1;
                    zero_to_end_next = 1'b0;
                    state_next       = S_ZERO;
                end
            end
            S_ZERO: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = fill_reg;
                ram_wr.data = 32'h0;
                if (zero_to_end_reg && fill_reg == 4'd15) begin
                    job_next   = JOB_EXTRA;
                    state_next = S_LOAD;
                end else if (!zero_to_end_reg && fill_reg == 4'd13) begin
                    state_next = S_LEN_LO;
                end else begin
                    fill_next = fill_reg + 4'd1;
                end
            end
            S_LEN_LO: begin
                // bit length = byte count * 8, modulo 2^64
                ram_wr.en   = 1'b1;
                ram_wr.addr = 4'd14;
                ram_wr.data = {cnt_reg[28:0], 3'b000};
                state_next  = S_LEN_HI;
            end
            S_LEN_HI: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = 4'd15;
                ram_wr.data = cnt_reg[60:29];
                job_next    = JOB_FINAL;
                state_next  = S_LOAD;
            end
            S_LOAD: begin
                wa_next    = chain_reg[0];
                wb_next    = chain_reg[1];
                wc_next    = chain_reg[2];
                wd_next    = chain_reg[3];
                rnd_next   = 6'd0;
                state_next = S_PRE;
            end
            S_PRE: begin
                pre_next   = ram_q + k_const(k_idx) + pre_base;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                pre_next = ram_q + k_const(k_idx) + pre_base;
                wa_next  = wd_reg;
                wb_next  = rot_val + wb_reg;
                wc_next  = wb_reg;
                wd_next  = wc_reg;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                chain_next[0] = chain_reg[0] + wa_reg;
                chain_next[1] = chain_reg[1] + wb_reg;
                chain_next[2] = chain_reg[2] + wc_reg;
                chain_next[3] = chain_reg[3] + wd_reg;
                case (job_reg)
                    JOB_DATA: begin
                        eom_pend_next = 1'b0;
                        state_next    = eom_pend_reg ? S_PAD : S_IDLE;
                    end
                    JOB_EXTRA: begin
                        fill_next        = 4'd0;
                        zero_to_end_next = 1'b0;
                        state_next       = S_ZERO;
                    end
                    JOB_FINAL: begin
                        state_next = S_DONE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DONE: begin
                // hand the digest over once the previous one has drained
                if (!out_busy_reg) begin
                    out_load      = 1'b1;
                    out_busy_next = 1'b1;
                    out_idx_next  = 2'd0;
                    chain_next[0] = IV_A;
                    chain_next[1] = IV_B;
                    chain_next[2] = IV_C;
                    chain_next[3] = IV_D;
                    cnt_next      = 64'd0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            job_reg         <= JOB_DATA;
            eom_pend_reg    <= 1'b0;
            cnt_reg         <= 64'd0;
            fill_reg        <= 4'd0;
            zero_to_end_reg <= 1'b0;
            rnd_reg         <= 6'd0;
            out_busy_reg    <= 1'b0;
            out_idx_reg     <= 2'd0;
            chain_reg[0]    <= IV_A;
            chain_reg[1]    <= IV_B;
            chain_reg[2]    <= IV_C;
            chain_reg[3]    <= IV_D;
        end else begin
            state_reg       <= state_next;
            job_reg         <= job_next;
            eom_pend_reg    <= eom_pend_next;
            cnt_reg         <= cnt_next;
            fill_reg        <= fill_next;
            zero_to_end_reg <= zero_to_end_next;
            rnd_reg         <= rnd_next;
            out_busy_reg    <= out_busy_next;
            out_idx_reg     <= out_idx_next;
            chain_reg       <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        pre_reg <= pre_next;
        wa_reg  <= wa_next;
        wb_reg  <= wb_next;
        wc_reg  <= wc_next;
        wd_reg  <= wd_next;
        if (out_load) begin
            out_word_reg <= chain_reg;
        end
    end

    assign m_axis_tvalid = out_busy_reg;
    assign m_axis_tdata  = out_word_reg[out_idx_reg];
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = (out_idx_reg == 2'd3);

    // checks
    `ASSERT_HOLDS(a_round_to_add, aclk, aresetn,
        (state_reg == S_ROUND && rnd_reg == 6'd63) |=> (state_reg == S_ADD),
        "compression did not finish after round 63")
    `ASSERT_NEVER(a_no_write_in_comp, aclk, aresetn,
        ram_wr.en && (state_reg == S_LOAD || state_reg == S_PRE || state_reg == S_ROUND),
        "block buffer written during compression")
    `ASSERT_HOLDS(a_full_block_starts, aclk, aresetn,
        (s_fire && s_axis_tuser[0] && cnt_reg[5:0] == 6'd63) |=> (state_reg == S_LOAD),
        "64th byte did not start a compression")
    `ASSERT_HOLDS(a_digest_drained, aclk, aresetn,
        $fell(out_busy_reg) |-> $past(m_axis_tready && out_idx_reg == 2'd3),
        "digest dropped before its last word was taken")

endmodule
